FILE: sv/euzyx_pkg.sv
package euzyx_pkg;

	localparam int ANGLE_FRAC_BITS = 8;
	localparam int COEF_FRAC_BITS  = 14;

	localparam int ANGLE_W  = 17;
	localparam int RED_W    = ANGLE_W + 1;
	localparam int OUT_W    = 16;
	localparam int TRIG_W   = 32;
	localparam int TRIG_FRAC = 30;
	localparam int PROD_W   = 64;
	localparam int Z_FRAC   = 20;
	localparam int Z_W      = 29;
	localparam int CORDIC_STEPS = 20;
	localparam int SINCOS_LAT = CORDIC_STEPS + 2;
	localparam int PIPE_LAT   = SINCOS_LAT + 5;
	localparam int RND_SH     = 2 * TRIG_FRAC - COEF_FRAC_BITS;
	localparam int RES_W      = PROD_W - RND_SH;

	localparam logic signed [TRIG_W-1:0] CORDIC_GAIN = 32'sd652032874;
	localparam logic signed [RED_W-1:0] ANG_FULL    = RED_W'(360 << ANGLE_FRAC_BITS);
	localparam logic signed [RED_W-1:0] ANG_HALF    = RED_W'(180 << ANGLE_FRAC_BITS);
	localparam logic signed [RED_W-1:0] ANG_QUARTER = RED_W'(90 << ANGLE_FRAC_BITS);
	localparam logic signed [OUT_W-1:0] COEF_ONE    = OUT_W'(1 << COEF_FRAC_BITS);

	function automatic logic signed [Z_W-1:0] atan_q20(input int step);
		logic signed [Z_W-1:0] v;
		case (step)
			0:  v = 29'sd47185920;
			1:  v = 29'sd27855475;
			2:  v = 29'sd14718068;
			3:  v = 29'sd7471121;
			4:  v = 29'sd3750058;
			5:  v = 29'sd1876857;
			6:  v = 29'sd938658;
			7:  v = 29'sd469357;
			8:  v = 29'sd234682;
			9:  v = 29'sd117342;
			10: v = 29'sd58671;
			11: v = 29'sd29335;
			12: v = 29'sd14668;
			13: v = 29'sd7334;
			14: v = 29'sd3667;
			15: v = 29'sd1833;
			16: v = 29'sd917;
			17: v = 29'sd458;
			18: v = 29'sd229;
			19: v = 29'sd115;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

FILE: sv/euzyx_sincos.sv
module euzyx_sincos
	import euzyx_pkg::*;
(
	input  logic                     clk,
	input  logic                     en,
	input  logic signed [ANGLE_W-1:0] angle,
	output logic signed [TRIG_W-1:0]  cos_val,
	output logic signed [TRIG_W-1:0]  sin_val
);

	logic signed [RED_W-1:0]  ang_ext;
	logic signed [RED_W-1:0]  ang_wrap;
	logic signed [RED_W-1:0]  ang_red;
	logic                     flip_in;
	logic signed [Z_W-1:0]    z_in;

	logic signed [TRIG_W-1:0] x_s [0:CORDIC_STEPS];
	logic signed [TRIG_W-1:0] y_s [0:CORDIC_STEPS];
	logic signed [Z_W-1:0]    z_s [0:CORDIC_STEPS];
	logic                     flip_s [0:CORDIC_STEPS];
	logic signed [TRIG_W-1:0] cos_s21;
	logic signed [TRIG_W-1:0] sin_s21;

	// wrap into [-180, 180), then fold into [-90, 90]
	always_comb begin
		ang_ext = RED_W'(angle);
		if (ang_ext >= ANG_HALF)
			ang_wrap = ang_ext - ANG_FULL;
		else if (ang_ext < -ANG_HALF)
			ang_wrap = ang_ext + ANG_FULL;
		else
			ang_wrap = ang_ext;
		if (ang_wrap > ANG_QUARTER) begin
			ang_red = ang_wrap - ANG_HALF;
			flip_in = 1'b1;
		end else if (ang_wrap < -ANG_QUARTER) begin
			ang_red = ang_wrap + ANG_HALF;
			flip_in = 1'b1;
		end else begin
			ang_red = ang_wrap;
			flip_in = 1'b0;
		end
		z_in = Z_W'(ang_red) <<< (Z_FRAC - ANGLE_FRAC_BITS);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0]    <= CORDIC_GAIN;
			y_s[0]    <= '0;
			z_s[0]    <= z_in;
			flip_s[0] <= flip_in;
		end
	end

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
		always_ff @(posedge clk) begin
			if (en) begin
				if (!z_s[i][Z_W-1]) begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - atan_q20(i);
				end else begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + atan_q20(i);
				end
				flip_s[i+1] <= flip_s[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cos_s21 <= flip_s[CORDIC_STEPS] ? -x_s[CORDIC_STEPS] : x_s[CORDIC_STEPS];
			sin_s21 <= flip_s[CORDIC_STEPS] ? -y_s[CORDIC_STEPS] : y_s[CORDIC_STEPS];
		end
	end

	assign cos_val = cos_s21;
	assign sin_val = sin_s21;

endmodule

FILE: sv/euler_zyx_rotation_matrix_unit.sv
// euler zyx rotation matrix unit
// input channel: in_valid / in_stall with roll_deg, pitch_deg, yaw_deg, each a
// signed angle in degrees with 8 fraction bits; any pattern wraps modulo 360
// output channel: out_valid / out_stall with the nine entries m_rowR_colC of
// Rz(yaw) * Ry(pitch) * Rx(roll), signed Q1.14, saturated to +-1.0
// one result beat for every input beat, in order
// pipeline: three parallel 20-step cordic pipelines, then stages that
// multiply, round and sum
// throughput: one beat per cycle while the receiver does not stall a waiting result
// the whole pipeline advances together; when the receiver stalls a waiting
// result, every stage holds and in_stall is raised, so nothing is lost
// reset clears the stage valid bits only; data registers are not reset
module euler_zyx_rotation_matrix_unit
	import euzyx_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic signed [ANGLE_W-1:0] roll_deg,
	input  logic signed [ANGLE_W-1:0] pitch_deg,
	input  logic signed [ANGLE_W-1:0] yaw_deg,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic signed [OUT_W-1:0]   m_row0_col0,
	output logic signed [OUT_W-1:0]   m_row0_col1,
	output logic signed [OUT_W-1:0]   m_row0_col2,
	output logic signed [OUT_W-1:0]   m_row1_col0,
	output logic signed [OUT_W-1:0]   m_row1_col1,
	output logic signed [OUT_W-1:0]   m_row1_col2,
	output logic signed [OUT_W-1:0]   m_row2_col0,
	output logic signed [OUT_W-1:0]   m_row2_col1,
	output logic signed [OUT_W-1:0]   m_row2_col2
);

	localparam int NUM_OUT = 9;

	logic en;
	logic [PIPE_LAT-1:0] vld_s;

	logic signed [TRIG_W-1:0] rc, rs, pc, ps, yc, ys;

	// stage 1: products
	logic signed [PROD_W-1:0] cysp_s1, sysp_s1;
	logic signed [PROD_W-1:0] p0_s1, p3_s1, p7_s1, p8_s1;
	logic signed [PROD_W-1:0] ysrc_s1, ysrs_s1, ycrc_s1, ycrs_s1;
	logic signed [TRIG_W-1:0] rc_s1, rs_s1, ps_s1;
	// stage 2: rounded pitch products
	logic signed [TRIG_W-1:0] cysp_s2, sysp_s2;
	logic signed [PROD_W-1:0] cysp_rnd, sysp_rnd;
	logic signed [PROD_W-1:0] p0_s2, p3_s2, p7_s2, p8_s2;
	logic signed [PROD_W-1:0] ysrc_s2, ysrs_s2, ycrc_s2, ycrs_s2;
	logic signed [TRIG_W-1:0] rc_s2, rs_s2, ps_s2;
	// stage 3: triple products
	logic signed [PROD_W-1:0] cysprs_s3, cysprc_s3, sysprs_s3, sysprc_s3;
	logic signed [PROD_W-1:0] p0_s3, p3_s3, p7_s3, p8_s3;
	logic signed [PROD_W-1:0] ysrc_s3, ysrs_s3, ycrc_s3, ycrs_s3;
	logic signed [TRIG_W-1:0] ps_s3;
	// stage 4: sums
	logic signed [PROD_W-1:0] m_s4 [0:NUM_OUT-1];
	// stage 5: rounded outputs
	logic signed [OUT_W-1:0]  m_s5 [0:NUM_OUT-1];
	logic signed [OUT_W-1:0]  m_sat [0:NUM_OUT-1];

	assign en       = !vld_s[PIPE_LAT-1] || !out_stall;
	assign in_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s <= '0;
		else if (en)
			vld_s <= {vld_s[PIPE_LAT-2:0], in_valid};
	end

	euzyx_sincos u_roll  (.clk(clk), .en(en), .angle(roll_deg),  .cos_val(rc), .sin_val(rs));
	euzyx_sincos u_pitch (.clk(clk), .en(en), .angle(pitch_deg), .cos_val(pc), .sin_val(ps));
	euzyx_sincos u_yaw   (.clk(clk), .en(en), .angle(yaw_deg),   .cos_val(yc), .sin_val(ys));

	always_ff @(posedge clk) begin
		if (en) begin
			cysp_s1 <= yc * ps;
			sysp_s1 <= ys * ps;
			p0_s1   <= yc * pc;
			p3_s1   <= ys * pc;
			p7_s1   <= pc * rs;
			p8_s1   <= pc * rc;
			ysrc_s1 <= ys * rc;
			ysrs_s1 <= ys * rs;
			ycrc_s1 <= yc * rc;
			ycrs_s1 <= yc * rs;
			rc_s1   <= rc;
			rs_s1   <= rs;
			ps_s1   <= ps;
		end
	end

	assign cysp_rnd = cysp_s1 + (PROD_W'(1) <<< (TRIG_FRAC - 1));
	assign sysp_rnd = sysp_s1 + (PROD_W'(1) <<< (TRIG_FRAC - 1));

	always_ff @(posedge clk) begin
		if (en) begin
			cysp_s2 <= cysp_rnd[TRIG_FRAC+TRIG_W-1:TRIG_FRAC];
			sysp_s2 <= sysp_rnd[TRIG_FRAC+TRIG_W-1:TRIG_FRAC];
			p0_s2   <= p0_s1;
			p3_s2   <= p3_s1;
			p7_s2   <= p7_s1;
			p8_s2   <= p8_s1;
			ysrc_s2 <= ysrc_s1;
			ysrs_s2 <= ysrs_s1;
			ycrc_s2 <= ycrc_s1;
			ycrs_s2 <= ycrs_s1;
			rc_s2   <= rc_s1;
			rs_s2   <= rs_s1;
			ps_s2   <= ps_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cysprs_s3 <= cysp_s2 * rs_s2;
			cysprc_s3 <= cysp_s2 * rc_s2;
			sysprs_s3 <= sysp_s2 * rs_s2;
			sysprc_s3 <= sysp_s2 * rc_s2;
			p0_s3     <= p0_s2;
			p3_s3     <= p3_s2;
			p7_s3     <= p7_s2;
			p8_s3     <= p8_s2;
			ysrc_s3   <= ysrc_s2;
			ysrs_s3   <= ysrs_s2;
			ycrc_s3   <= ycrc_s2;
			ycrs_s3   <= ycrs_s2;
			ps_s3     <= ps_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_s4[0] <= p0_s3;
			m_s4[1] <= cysprs_s3 - ysrc_s3;
			m_s4[2] <= cysprc_s3 + ysrs_s3;
			m_s4[3] <= p3_s3;
			m_s4[4] <= sysprs_s3 + ycrc_s3;
			m_s4[5] <= sysprc_s3 - ycrs_s3;
			m_s4[6] <= -(PROD_W'(ps_s3) <<< TRIG_FRAC);
			m_s4[7] <= p7_s3;
			m_s4[8] <= p8_s3;
		end
	end

	// round half up to Q1.14, then clamp to +-1.0
	for (genvar k = 0; k < NUM_OUT; k++) begin : g_out
		logic signed [PROD_W-1:0] rnd;
		logic signed [RES_W-1:0]  res;
		always_comb begin
			rnd = m_s4[k] + (PROD_W'(1) <<< (RND_SH - 1));
			res = rnd[PROD_W-1:RND_SH];
			if (res > RES_W'(COEF_ONE))
				m_sat[k] = COEF_ONE;
			else if (res < -RES_W'(COEF_ONE))
				m_sat[k] = -COEF_ONE;
			else
				m_sat[k] = res[OUT_W-1:0];
		end
		always_ff @(posedge clk) begin
			if (en)
				m_s5[k] <= m_sat[k];
		end
	end

	assign out_valid   = vld_s[PIPE_LAT-1];
	assign m_row0_col0 = m_s5[0];
	assign m_row0_col1 = m_s5[1];
	assign m_row0_col2 = m_s5[2];
	assign m_row1_col0 = m_s5[3];
	assign m_row1_col1 = m_s5[4];
	assign m_row1_col2 = m_s5[5];
	assign m_row2_col0 = m_s5[6];
	assign m_row2_col1 = m_s5[7];
	assign m_row2_col2 = m_s5[8];

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(vld_s))
		else $error("pipeline moved while result stalled");

	a_sat_00: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (m_row0_col0 <= COEF_ONE) && (m_row0_col0 >= -COEF_ONE))
		else $error("m_row0_col0 beyond one");

	a_sat_11: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (m_row1_col1 <= COEF_ONE) && (m_row1_col1 >= -COEF_ONE))
		else $error("m_row1_col1 beyond one");

	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> vld_s[0])
		else $error("accepted beat lost at entry");

endmodule

FILE: tb/sv/tb_euler_zyx_rotation_matrix_unit.sv
`timescale 1ns / 100ps

module tb_euler_zyx_rotation_matrix_unit;
	import euzyx_pkg::*;

	typedef struct {
		logic signed [ANGLE_W-1:0] roll;
		logic signed [ANGLE_W-1:0] pitch;
		logic signed [ANGLE_W-1:0] yaw;
	} angles_t;

	typedef struct {
		logic [OUT_W-1:0] m [9];
	} matrix_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [ANGLE_W-1:0] roll_deg = '0;
	logic signed [ANGLE_W-1:0] pitch_deg = '0;
	logic signed [ANGLE_W-1:0] yaw_deg = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [OUT_W-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;

	angles_t pending_angles [$];
	matrix_t expected_matrices [$];
	int errors = 0;
	int send_idle_pct = 0;
	int stall_pct = 0;
	bit stim_done = 0;
	bit in_taken = 1'b0;

	euler_zyx_rotation_matrix_unit uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.roll_deg(roll_deg), .pitch_deg(pitch_deg), .yaw_deg(yaw_deg),
		.out_valid(out_valid), .out_stall(out_stall),
		.m_row0_col0(m00), .m_row0_col1(m01), .m_row0_col2(m02),
		.m_row1_col0(m10), .m_row1_col1(m11), .m_row1_col2(m12),
		.m_row2_col0(m20), .m_row2_col1(m21), .m_row2_col2(m22)
	);

	always #10 clk = ~clk;

	function automatic longint floor_shift(longint v, int sh);
		return v >>> sh;
	endfunction

	function automatic void sin_cos(input logic signed [ANGLE_W-1:0] ang,
			output longint c, output longint s);
		longint full, half, quarter, a, x, y, z, dx, dy;
		bit flip;
		full = 360 << ANGLE_FRAC_BITS;
		half = 180 << ANGLE_FRAC_BITS;
		quarter = 90 << ANGLE_FRAC_BITS;
		flip = 0;
		a = longint'(ang) % full;
		if (a < 0) a += full;
		if (a >= half) a -= full;
		if (a > quarter) begin
			a -= half;
			flip = 1;
		end else if (a < -quarter) begin
			a += half;
			flip = 1;
		end
		z = a * (longint'(1) << (Z_FRAC - ANGLE_FRAC_BITS));
		x = 652032874;
		y = 0;
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			dx = floor_shift(y, i);
			dy = floor_shift(x, i);
			if (z >= 0) begin
				x -= dx;
				y += dy;
				z -= longint'(atan_q20(i));
			end else begin
				x += dx;
				y -= dy;
				z += longint'(atan_q20(i));
			end
		end
		c = flip ? -x : x;
		s = flip ? -y : y;
	endfunction

	function automatic longint round_q30(longint a, longint b);
		return floor_shift(a * b + (longint'(1) << 29), TRIG_FRAC);
	endfunction

	function automatic logic [OUT_W-1:0] coef_out(longint v);
		longint r, one;
		one = longint'(1) << COEF_FRAC_BITS;
		r = floor_shift(v + (longint'(1) << (RND_SH - 1)), RND_SH);
		if (r > one) r = one;
		if (r < -one) r = -one;
		return r[OUT_W-1:0];
	endfunction

	function automatic matrix_t rotation_matrix(angles_t a);
		longint cr, sr, cp, sp, cy, sy, cysp, sysp;
		matrix_t q;
		sin_cos(a.roll, cr, sr);
		sin_cos(a.pitch, cp, sp);
		sin_cos(a.yaw, cy, sy);
		cysp = round_q30(cy, sp);
		sysp = round_q30(sy, sp);
		q.m[0] = coef_out(cy * cp);
		q.m[1] = coef_out(cysp * sr - sy * cr);
		q.m[2] = coef_out(cysp * cr + sy * sr);
		q.m[3] = coef_out(sy * cp);
		q.m[4] = coef_out(sysp * sr + cy * cr);
		q.m[5] = coef_out(sysp * cr - cy * sr);
		q.m[6] = coef_out(-sp * (longint'(1) << TRIG_FRAC));
		q.m[7] = coef_out(cp * sr);
		q.m[8] = coef_out(cp * cr);
		return q;
	endfunction

	function automatic logic signed [ANGLE_W-1:0] rand_angle();
		case ($urandom_range(0, 9))
			0: return ANGLE_W'($urandom);
			1: return ANGLE_W'(($urandom_range(0, 8) * 45 - 180) << ANGLE_FRAC_BITS)
				+ ANGLE_W'(int'($urandom_range(0, 2)) - 1);
			default: return ANGLE_W'(int'($urandom_range(0, 92160)) - 46080);
		endcase
	endfunction

	task automatic push_angles(int r, int p, int y);
		angles_t a;
		a.roll = ANGLE_W'(r);
		a.pitch = ANGLE_W'(p);
		a.yaw = ANGLE_W'(y);
		pending_angles.push_back(a);
	endtask

	// input beat taken at the last rising edge
	always @(posedge clk) begin
		in_taken <= in_valid && !in_stall;
	end

	// driver
	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_valid || in_taken) begin
				if (in_valid) begin
					expected_matrices.push_back(rotation_matrix(pending_angles.pop_front()));
				end
				if (pending_angles.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					in_valid <= 1'b1;
					roll_deg <= pending_angles[0].roll;
					pitch_deg <= pending_angles[0].pitch;
					yaw_deg <= pending_angles[0].yaw;
				end else begin
					in_valid <= 1'b0;
				end
			end
			out_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	// monitor
	always @(posedge clk) begin
		logic [OUT_W-1:0] got [9];
		matrix_t want;
		if (arst_n && out_valid && !out_stall) begin
			got = '{m00, m01, m02, m10, m11, m12, m20, m21, m22};
			if (expected_matrices.size() == 0) begin
				$display("%0t: unexpected result beat", $time);
				errors++;
			end else begin
				want = expected_matrices.pop_front();
				for (int i = 0; i < 9; i++)
					if (got[i] !== want.m[i]) begin
						$display("%0t: m[%0d] expected %h actual %h", $time, i,
							want.m[i], got[i]);
						errors++;
					end
			end
		end
	end

	initial begin
		int vals [7] = '{-46080, 46080, 0, 23040, -23040, 65535, -65536};
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		for (int i = 0; i < 7; i++) push_angles(vals[i], vals[(i+2)%7], vals[(i+4)%7]);
		push_angles(46080, 0, 0);
		push_angles(0, 46080, 0);
		push_angles(0, 0, 46080);
		push_angles(0, 23040, 0);
		push_angles(0, -23040, 0);
		push_angles(23041, 23039, -23041);
		push_angles(92160, -92160, 92161);
		push_angles(1, -1, 0);
		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0; stall_pct = 0; end
				1: begin send_idle_pct = 87; stall_pct = 0; end
				2: begin send_idle_pct = 0; stall_pct = 87; end
				3: begin send_idle_pct = 17; stall_pct = 17; end
				default: begin send_idle_pct = 0; stall_pct = 0; end
			endcase
			repeat (280) begin
				angles_t a;
				a.roll = rand_angle();
				a.pitch = rand_angle();
				a.yaw = rand_angle();
				pending_angles.push_back(a);
			end
			while (pending_angles.size() > 0) @(posedge clk);
		end
		while (in_valid || expected_matrices.size() > 0) @(posedge clk);
		repeat (PIPE_LAT + 10) @(posedge clk);
		if (errors == 0)
			$display("euler_zyx_rotation_matrix_unit verification clean");
		else
			$display("euler_zyx_rotation_matrix_unit verification failed");
		$finish;
	end

	initial begin
		#20ms;
		$display("euler_zyx_rotation_matrix_unit verification failed");
		$finish;
	end
endmodule

FILE: filelist.f
sv/euzyx_pkg.sv
sv/euzyx_sincos.sv
sv/euler_zyx_rotation_matrix_unit.sv
tb/sv/tb_euler_zyx_rotation_matrix_unit.sv
